// ===== rtl/skt_pkg.sv =====
// shared widths, codes and interface types for the sorted key table
// no dependencies; imported by the engine, the top level and the checker
package skt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;

    localparam int OPC_W  = 3;
    localparam int KEY_W  = 31;
    localparam int HDL_W  = 16;
    localparam int POS_W  = 6;
    localparam int STS_W  = 3;
    localparam int FPOS_W = 7;
    localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam int ENTRY_W     = KEY_W + HDL_W;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    typedef enum logic [OPC_W-1:0] {
        OP_LOOKUP     = 3'd0,
        OP_INSERT     = 3'd1,
        OP_REMOVE_KEY = 3'd2,
        OP_READ_POS   = 3'd3,
        OP_REMOVE_POS = 3'd4
    } t_opcode;

    typedef enum logic [STS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_POS   = 3'd4
    } t_status;

    // register index, decoded from the word address
    typedef enum logic {
        REG_DESCENDING  = 1'b0,
        REG_UNIQUE_KEYS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [HDL_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic descending;
        logic unique_keys;
    } t_cfg;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_ram_req;

    typedef struct packed {
        t_status           status;
        logic [FPOS_W-1:0] found_position;
        logic [KEY_W-1:0]  found_key;
        logic [HDL_W-1:0]  found_handle;
        logic [FPOS_W-1:0] count;
    } t_result;

endpackage

// ===== rtl/skt_ram.sv =====
// generic single-port-write, single-port-read synchronous ram
// read data is registered; no dependencies
module skt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/skt_engine.sv =====
// operation sequencer: binary search, position read and shift passes over the entry ram
// depends on skt_pkg; drives one skt_ram through a t_ram_req
module skt_engine
    import skt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_opcode  i_opcode,
    input  logic [KEY_W-1:0] i_key,
    input  logic [HDL_W-1:0] i_handle,
    input  logic [POS_W-1:0] i_position,
    output logic     o_res_valid,
    input  logic     i_res_ready,
    output t_result  o_result,
    output t_ram_req o_ram,
    input  t_entry   i_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_POS_RD,
        S_POS_CMP,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    t_opcode r_op, n_op;
    logic [KEY_W-1:0] r_key, n_key;
    logic [HDL_W-1:0] r_handle, n_handle;
    logic [POS_W-1:0] r_position, n_position;
    logic [CNT_W-1:0] r_low, n_low;
    logic [CNT_W-1:0] r_hp1, n_hp1;
    logic [IDX_W-1:0] r_mid, n_mid;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_count, n_count;
    t_status r_res_status, n_res_status;
    logic [FPOS_W-1:0] r_res_fpos, n_res_fpos;
    logic [KEY_W-1:0] r_res_key, n_res_key;
    logic [HDL_W-1:0] r_res_handle, n_res_handle;
    logic r_ins, n_ins;
    logic [IDX_W-1:0] r_src, n_src;
    logic [CNT_W-1:0] r_left, n_left;
    logic r_wpend, n_wpend;
    logic [IDX_W-1:0] r_wdst, n_wdst;
    logic r_out_valid, n_out_valid;
    t_result r_out, n_out;

    logic [CNT_W:0]   mid_sum;
    logic [IDX_W-1:0] mid;
    logic             key_eq;
    logic             go_low;
    logic             full;
    logic             do_ins;
    logic             do_rem;
    logic [CNT_W-1:0] sh_pos;
    t_ram_req         ram;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_handle     = r_handle;
        n_position   = r_position;
        n_low        = r_low;
        n_hp1        = r_hp1;
        n_mid        = r_mid;
        n_pos        = r_pos;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_fpos   = r_res_fpos;
        n_res_key    = r_res_key;
        n_res_handle = r_res_handle;
        n_ins        = r_ins;
        n_src        = r_src;
        n_left       = r_left;
        n_wpend      = r_wpend;
        n_wdst       = r_wdst;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_res_ready;
        ram          = '0;
        do_ins       = 1'b0;
        do_rem       = 1'b0;
        sh_pos       = '0;

        // midpoint of [low, hp1-1]
        mid_sum = {1'b0, r_low} + {1'b0, r_hp1} - (CNT_W+1)'(1);
        mid     = mid_sum[IDX_W:1];
        key_eq  = (i_rd_data.key == r_key);
        go_low  = i_cfg.descending ? (i_rd_data.key < r_key) : (i_rd_data.key > r_key);
        full    = (r_count >= CNT_W'(CAPACITY));

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op         = i_opcode;
                    n_key        = i_key;
                    n_handle     = i_handle;
                    n_position   = i_position;
                    n_low        = '0;
                    n_hp1        = r_count;
                    n_res_status = ST_NOT_FOUND;
                    n_res_fpos   = '0;
                    n_res_key    = '0;
                    n_res_handle = '0;
                    case (i_opcode)
                        OP_LOOKUP, OP_REMOVE_KEY: begin
                            // key zero is never found, even when stored
                            n_state = (i_key == '0) ? S_DONE : S_SRCH_RD;
                        end
                        OP_INSERT: begin
                            n_state = S_SRCH_RD;
                        end
                        OP_READ_POS, OP_REMOVE_POS: begin
                            n_state = S_POS_RD;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SRCH_RD: begin
                if (r_low < r_hp1) begin
                    ram.rd_en   = 1'b1;
                    ram.rd_addr = mid;
                    n_mid       = mid;
                    n_state     = S_SRCH_CMP;
                end else begin
                    // miss: low is the insertion point
                    n_res_fpos   = FPOS_W'(r_low);
                    n_res_key    = '0;
                    n_res_handle = '0;
                    n_res_status = ST_NOT_FOUND;
                    n_state      = S_DONE;
                    if (r_op == OP_INSERT) begin
                        if (full) begin
                            n_res_status = ST_FULL;
                        end else begin
                            do_ins = 1'b1;
                            sh_pos = r_low;
                        end
                    end
                end
            end

            S_SRCH_CMP: begin
                if (key_eq) begin
                    n_res_fpos   = FPOS_W'(r_mid);
                    n_res_key    = i_rd_data.key;
                    n_res_handle = i_rd_data.handle;
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                    case (r_op)
                        OP_REMOVE_KEY: begin
                            do_rem = 1'b1;
                            sh_pos = CNT_W'(r_mid);
                        end
                        OP_INSERT: begin
                            if (i_cfg.unique_keys) begin
                                n_res_status = ST_DUPLICATE;
                            end else if (full) begin
                                n_res_status = ST_FULL;
                                n_res_key    = '0;
                                n_res_handle = '0;
                            end else begin
                                do_ins = 1'b1;
                                sh_pos = CNT_W'(r_mid);
                            end
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    if (go_low) begin
                        n_hp1 = CNT_W'(r_mid);
                    end else begin
                        n_low = CNT_W'(r_mid) + CNT_W'(1);
                    end
                    n_state = S_SRCH_RD;
                end
            end

            S_POS_RD: begin
                n_res_fpos = FPOS_W'(r_position);
                if (CMP_W'(r_position) >= CMP_W'(r_count)) begin
                    n_res_status = ST_BAD_POS;
                    n_state      = S_DONE;
                end else begin
                    ram.rd_en   = 1'b1;
                    ram.rd_addr = IDX_W'(r_position);
                    n_state     = S_POS_CMP;
                end
            end

            S_POS_CMP: begin
                n_res_status = ST_OK;
                n_res_key    = i_rd_data.key;
                n_res_handle = i_rd_data.handle;
                n_state      = S_DONE;
                if (r_op == OP_REMOVE_POS) begin
                    do_rem = 1'b1;
                    sh_pos = CNT_W'(r_position);
                end
            end

            S_SHIFT: begin
                // read one entry and write the previous one back in the same cycle;
                // the addresses never coincide, so no forwarding is needed
                if (r_wpend) begin
                    ram.wr_en   = 1'b1;
                    ram.wr_addr = r_wdst;
                    ram.wr_data = i_rd_data;
                end
                if (r_left != '0) begin
                    ram.rd_en   = 1'b1;
                    ram.rd_addr = r_src;
                    n_wpend     = 1'b1;
                    n_wdst      = r_ins ? (r_src + IDX_W'(1)) : (r_src - IDX_W'(1));
                    n_src       = r_ins ? (r_src - IDX_W'(1)) : (r_src + IDX_W'(1));
                    n_left      = r_left - CNT_W'(1);
                end else begin
                    n_wpend = 1'b0;
                    if (!r_wpend) begin
                        if (r_ins) begin
                            ram.wr_en          = 1'b1;
                            ram.wr_addr        = IDX_W'(r_pos);
                            ram.wr_data.key    = r_key;
                            ram.wr_data.handle = r_handle;
                        end
                        n_state = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out.status         = r_res_status;
                    n_out.found_position = r_res_fpos;
                    n_out.found_key      = r_res_key;
                    n_out.found_handle   = r_res_handle;
                    n_out.count          = FPOS_W'(r_count);
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_ins) begin
            n_ins        = 1'b1;
            n_pos        = sh_pos;
            n_left       = r_count - sh_pos;
            n_src        = IDX_W'(r_count - CNT_W'(1));
            n_wpend      = 1'b0;
            n_count      = r_count + CNT_W'(1);
            n_res_status = ST_OK;
            n_res_fpos   = FPOS_W'(sh_pos);
            n_res_key    = r_key;
            n_res_handle = r_handle;
            n_state      = S_SHIFT;
        end
        if (do_rem) begin
            n_ins   = 1'b0;
            n_pos   = sh_pos;
            n_left  = r_count - CNT_W'(1) - sh_pos;
            n_src   = IDX_W'(sh_pos + CNT_W'(1));
            n_wpend = 1'b0;
            n_count = r_count - CNT_W'(1);
            n_state = S_SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_wpend     <= n_wpend;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_key        <= n_key;
        r_handle     <= n_handle;
        r_position   <= n_position;
        r_low        <= n_low;
        r_hp1        <= n_hp1;
        r_mid        <= n_mid;
        r_pos        <= n_pos;
        r_res_status <= n_res_status;
        r_res_fpos   <= n_res_fpos;
        r_res_key    <= n_res_key;
        r_res_handle <= n_res_handle;
        r_ins        <= n_ins;
        r_src        <= n_src;
        r_left       <= n_left;
        r_wdst       <= n_wdst;
        r_out        <= n_out;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_result    = r_out;
    assign o_ram       = ram;

endmodule

// ===== rtl/sorted_key_table.sv =====
// top level of the sorted key table: apb registers, sequencer and entry ram
// depends on skt_pkg, skt_ram and skt_engine
//
//  channel   direction  handshake             payload
//  request   in         i_valid / o_ready     i_opcode i_key i_handle i_position
//  response  out        o_valid / i_ready     o_status o_found_position o_found_key
//                                             o_found_handle o_count
//  config    in         apb psel/penable      paddr pwdata -> prdata (pready tied high)
//
// one request at a time; a lookup runs one binary search probe after another, each a
// ram read, then a compare, through the single ram read port
// insert and remove then shift the entries that move: the shift streams one read and one
// write-back per cycle through the ram
// a finished response sits in the output register, so the next request is taken while
// it waits; a stalled response only holds the engine once the next one is ready
// synchronous active-low reset clears the entry count and valid flags; ram contents
// are left as they are and are never read beyond the count
module sorted_key_table
    import skt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [OPC_W-1:0]      i_opcode,
    input  logic [KEY_W-1:0]      i_key,
    input  logic [HDL_W-1:0]      i_handle,
    input  logic [POS_W-1:0]      i_position,

    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [STS_W-1:0]      o_status,
    output logic [FPOS_W-1:0]     o_found_position,
    output logic [KEY_W-1:0]      o_found_key,
    output logic [HDL_W-1:0]      o_found_handle,
    output logic [FPOS_W-1:0]     o_count,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // configuration registers
    logic     r_descending;
    logic     r_unique_keys;
    logic     cfg_wr;
    t_reg_idx reg_idx;
    t_cfg     cfg;

    // engine <-> ram
    t_ram_req ram_req;
    t_entry   rd_data;
    t_result  result;

    // register index sits at word granularity
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_descending  <= 1'b0;
            r_unique_keys <= 1'b1;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_DESCENDING:  r_descending  <= pwdata[0];
                REG_UNIQUE_KEYS: r_unique_keys <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // read mux, one bit registers zero-extended
    always_comb begin
        case (reg_idx)
            REG_DESCENDING:  prdata = APB_DATA_W'(r_descending);
            REG_UNIQUE_KEYS: prdata = APB_DATA_W'(r_unique_keys);
            default:         prdata = '0;
        endcase
    end

    assign cfg.descending  = r_descending;
    assign cfg.unique_keys = r_unique_keys;

    // sequencer: search, position read, shift passes and the response register
    skt_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req_valid (i_valid),
        .o_req_ready (o_ready),
        .i_opcode    (t_opcode'(i_opcode)),
        .i_key       (i_key),
        .i_handle    (i_handle),
        .i_position  (i_position),
        .o_res_valid (o_valid),
        .i_res_ready (i_ready),
        .o_result    (result),
        .o_ram       (ram_req),
        .i_rd_data   (rd_data)
    );

    // key and handle live side by side in one ram word
    skt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.wr_en),
        .i_waddr (ram_req.wr_addr),
        .i_wdata (ram_req.wr_data),
        .i_re    (ram_req.rd_en),
        .i_raddr (ram_req.rd_addr),
        .o_rdata (rd_data)
    );

    assign o_status         = result.status;
    assign o_found_position = result.found_position;
    assign o_found_key      = result.found_key;
    assign o_found_handle   = result.found_handle;
    assign o_count          = result.count;

endmodule

// ===== rtl/skt_checker.sv =====
// port-level checks for the sorted key table, attached by bind
// depends on skt_pkg and the sorted_key_table port list
module skt_checker
    import skt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic [STS_W-1:0]  o_status,
    input logic [FPOS_W-1:0] o_found_position,
    input logic [KEY_W-1:0]  o_found_key,
    input logic [HDL_W-1:0]  o_found_handle,
    input logic [FPOS_W-1:0] o_count
);

    // a stalled response stays valid and keeps its status, found key and count
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_found_key)
            && $stable(o_count))
        else $error("response changed while stalled");

    // the table never holds more than its capacity
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_count <= FPOS_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // not-found, full and bad-position responses report no entry
    a_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_NOT_FOUND || o_status == ST_FULL
            || o_status == ST_BAD_POS)
        |-> o_found_key == '0 && o_found_handle == '0)
        else $error("entry reported on a failed request");

    // a bad position lies at or beyond the unchanged count
    a_bad_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_BAD_POS |-> o_found_position >= o_count)
        else $error("bad position inside the table");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_status         (o_status),
    .o_found_position (o_found_position),
    .o_found_key      (o_found_key),
    .o_found_handle   (o_found_handle),
    .o_count          (o_count)
);

// ===== verif/sorted_key_table_checker.sv =====
// checker for the sorted key table: watches the request, response and apb channels
// keeps its own copy of the table and compares every response; depends on skt_pkg
`timescale 1ns / 100ps

module sorted_key_table_checker
    import skt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [OPC_W-1:0]      i_opcode,
    input  logic [KEY_W-1:0]      i_key,
    input  logic [HDL_W-1:0]      i_handle,
    input  logic [POS_W-1:0]      i_position,

    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_ready,
    input  logic [STS_W-1:0]      i_status,
    input  logic [FPOS_W-1:0]     i_found_position,
    input  logic [KEY_W-1:0]      i_found_key,
    input  logic [HDL_W-1:0]      i_found_handle,
    input  logic [FPOS_W-1:0]     i_count,

    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,

    output int                    o_fail_count,
    output int                    o_pending
);

    // shadow table
    logic [KEY_W-1:0] tbl_key    [CAPACITY];
    logic [HDL_W-1:0] tbl_handle [CAPACITY];
    int               entry_cnt   = 0;
    logic             order_desc  = 1'b0;
    logic             unique_mode = 1'b1;

    t_result          expected_q [$];
    int               fail_cnt = 0;

    // midpoint binary search: match position or insertion point
    function automatic int find_slot(input logic [KEY_W-1:0] key, output logic hit);
        int lo;
        int hi;
        int mid;
        lo  = 0;
        hi  = entry_cnt - 1;
        hit = 1'b0;
        while (lo <= hi) begin
            mid = (lo + hi) >> 1;
            if (tbl_key[mid] == key) begin
                hit = 1'b1;
                return mid;
            end
            if (order_desc ? (tbl_key[mid] < key) : (tbl_key[mid] > key))
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic void drop_entry(input int pos);
        for (int k = pos; k + 1 < entry_cnt; k++) begin
            tbl_key[k]    = tbl_key[k + 1];
            tbl_handle[k] = tbl_handle[k + 1];
        end
        entry_cnt--;
    endfunction

    function automatic t_result predict_table_op(input logic [OPC_W-1:0] op,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [HDL_W-1:0] handle,
                                                 input logic [POS_W-1:0] pos);
        t_result r;
        int      slot;
        logic    hit;
        r = '0;
        r.status = ST_NOT_FOUND;
        case (op)
            OP_LOOKUP, OP_REMOVE_KEY: begin
                // key zero is never found
                if (key != '0) begin
                    slot = find_slot(key, hit);
                    r.found_position = FPOS_W'(slot);
                    if (hit) begin
                        r.status       = ST_OK;
                        r.found_key    = tbl_key[slot];
                        r.found_handle = tbl_handle[slot];
                        if (op == OP_REMOVE_KEY)
                            drop_entry(slot);
                    end
                end
            end
            OP_INSERT: begin
                slot = find_slot(key, hit);
                r.found_position = FPOS_W'(slot);
                if (hit && unique_mode) begin
                    r.status       = ST_DUPLICATE;
                    r.found_key    = tbl_key[slot];
                    r.found_handle = tbl_handle[slot];
                end else if (entry_cnt >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (int k = entry_cnt; k > slot; k--) begin
                        tbl_key[k]    = tbl_key[k - 1];
                        tbl_handle[k] = tbl_handle[k - 1];
                    end
                    tbl_key[slot]    = key;
                    tbl_handle[slot] = handle;
                    entry_cnt++;
                    r.status       = ST_OK;
                    r.found_key    = key;
                    r.found_handle = handle;
                end
            end
            OP_READ_POS, OP_REMOVE_POS: begin
                r.found_position = FPOS_W'(pos);
                if (int'(pos) >= entry_cnt) begin
                    r.status = ST_BAD_POS;
                end else begin
                    r.status       = ST_OK;
                    r.found_key    = tbl_key[pos];
                    r.found_handle = tbl_handle[pos];
                    if (op == OP_REMOVE_POS)
                        drop_entry(int'(pos));
                end
            end
            default: ;
        endcase
        r.count = FPOS_W'(entry_cnt);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            fail_cnt++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            entry_cnt   = 0;
            order_desc  = 1'b0;
            unique_mode = 1'b1;
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[APB_ADDR_W-1:2]))
                    REG_DESCENDING:  order_desc  = i_pwdata[0];
                    REG_UNIQUE_KEYS: unique_mode = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected response, expected none, got status %0d key %0h",
                             $time, i_status, i_found_key);
                end else begin
                    exp_res = expected_q.pop_front();
                    check_field("status", 32'(exp_res.status), 32'(i_status));
                    check_field("found_position", 32'(exp_res.found_position),
                                32'(i_found_position));
                    check_field("found_key", 32'(exp_res.found_key), 32'(i_found_key));
                    check_field("found_handle", 32'(exp_res.found_handle),
                                32'(i_found_handle));
                    check_field("count", 32'(exp_res.count), 32'(i_count));
                end
            end
            if (i_req_valid && i_req_ready)
                expected_q.push_back(predict_table_op(i_opcode, i_key, i_handle, i_position));
        end
        o_fail_count = fail_cnt;
        o_pending    = expected_q.size();
    end

endmodule

// ===== verif/sorted_key_table_tb.sv =====
// testbench top for the sorted key table: clock, reset, request and apb stimulus, verdict
// depends on skt_pkg, sorted_key_table and sorted_key_table_checker
`timescale 1ns / 100ps

module sorted_key_table_tb
    import skt_pkg::*;
();

    // cycles without any accepted request, response or register write before giving up
    localparam int WATCHDOG_LIMIT = 4000;
    // length of the long response hold-off that backs the table up
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_ITEMS    = 300;

    logic                  i_clk;
    logic                  i_rst_n;

    logic                  i_valid;
    logic                  o_ready;
    logic [OPC_W-1:0]      i_opcode;
    logic [KEY_W-1:0]      i_key;
    logic [HDL_W-1:0]      i_handle;
    logic [POS_W-1:0]      i_position;

    logic                  o_valid;
    logic                  i_ready;
    logic [STS_W-1:0]      o_status;
    logic [FPOS_W-1:0]     o_found_position;
    logic [KEY_W-1:0]      o_found_key;
    logic [HDL_W-1:0]      o_found_handle;
    logic [FPOS_W-1:0]     o_count;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    fail_count;
    int                    pending;

    // shared between the sender, the receiver and the phase sequencing; quiet_cycles is the watchdog's own
    logic                  idle_on       = 1'b1;
    int                    long_hold_req = 0;
    logic                  rx_enable     = 1'b0;
    int                    quiet_cycles  = 0;

    sorted_key_table DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_opcode         (i_opcode),
        .i_key            (i_key),
        .i_handle         (i_handle),
        .i_position       (i_position),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_found_key      (o_found_key),
        .o_found_handle   (o_found_handle),
        .o_count          (o_count),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    sorted_key_table_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_ready      (o_ready),
        .i_opcode         (i_opcode),
        .i_key            (i_key),
        .i_handle         (i_handle),
        .i_position       (i_position),
        .i_rsp_valid      (o_valid),
        .i_rsp_ready      (i_ready),
        .i_status         (o_status),
        .i_found_position (o_found_position),
        .i_found_key      (o_found_key),
        .i_found_handle   (o_found_handle),
        .i_count          (o_count),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // offer one request: random gap with valid low, then hold valid and payload until taken
    // called right after the previous acceptance edge, so valid changes once per falling edge
    task automatic send_request(input logic [OPC_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [HDL_W-1:0] handle,
                                input logic [POS_W-1:0] pos);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode   = op;
        i_key      = key;
        i_handle   = handle;
        i_position = pos;
        i_valid    = 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // drop valid and wait until every predicted response has come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // apb write: setup cycle then access cycle, pready is tied high
    task automatic write_register(input t_reg_idx idx, input logic value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'(idx) << 2;
        // upper data bits are don't-care, drive them random
        pwdata  = {$urandom()} & ~32'h1 | APB_DATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // random requests in three stretches: grow toward full, shrink, then a mix
    // a few reserved opcodes are thrown in as noise
    task automatic random_phase(input logic do_hold);
        int               r;
        int               t_ins;
        int               t_look;
        int               t_rmk;
        int               t_read;
        logic [OPC_W-1:0] op;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            // back the response side up once while requests keep coming
            if (do_hold && i == 20)
                long_hold_req++;
            // a stretch with no idling on either side
            idle_on = !(i >= 230 && i < 280);
            if (i < 130) begin
                t_ins = 80; t_look = 88; t_rmk = 92; t_read = 96;
            end else if (i < 230) begin
                t_ins = 10; t_look = 25; t_rmk = 60; t_read = 70;
            end else begin
                t_ins = 30; t_look = 50; t_rmk = 65; t_read = 80;
            end
            r = $urandom_range(0, 99);
            if (r < 3)
                op = OPC_W'($urandom_range(5, 7));
            else begin
                r = $urandom_range(0, 99);
                if (r < t_ins)        op = OP_INSERT;
                else if (r < t_look)  op = OP_LOOKUP;
                else if (r < t_rmk)   op = OP_REMOVE_KEY;
                else if (r < t_read)  op = OP_READ_POS;
                else                  op = OP_REMOVE_POS;
            end
            // mostly a small key pool so inserts collide and lookups hit
            r = $urandom_range(0, 99);
            if (r < 8)        key = '0;
            else if (r < 80)  key = KEY_W'($urandom_range(1, 150));
            else if (r < 84)  key = '1;
            else              key = KEY_W'($urandom());
            if ($urandom_range(0, 1))
                pos = POS_W'($urandom_range(0, 7));
            else
                pos = POS_W'($urandom_range(0, 63));
            send_request(op, key, HDL_W'($urandom_range(0, 65535)), pos);
        end
        idle_on = 1'b1;
    endtask

    // response side: random ready gaps, plus the long hold-off when asked
    initial begin
        int gap;
        int holds_done;
        holds_done = 0;
        i_ready    = 1'b0;
        wait (rx_enable);
        forever begin
            @(negedge i_clk);
            if (long_hold_req != holds_done) begin
                holds_done++;
                i_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            gap = idle_on ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                i_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // watchdog: ends the run when nothing moves for too long
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("sorted_key_table_tb NOT OK");
        $finish;
    end

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_opcode   = '0;
        i_key      = '0;
        i_handle   = '0;
        i_position = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n   = 1'b1;
        rx_enable = 1'b1;

        // directed part, with the reset configuration: ascending, unique keys
        send_request(OP_LOOKUP, '0, '0, '0);                 // key zero, empty table
        send_request(OP_READ_POS, 31'd9, '0, '0);            // bad position on empty table
        send_request(OP_REMOVE_POS, '0, '0, '1);             // highest position, bad
        send_request(OP_INSERT, '1, '1, '0);                 // largest key and handle
        send_request(OP_INSERT, '0, '0, '0);                 // key zero may be stored
        send_request(OP_INSERT, 31'd5, 16'h1234, '0);
        send_request(OP_INSERT, 31'd5, 16'habcd, '0);        // duplicate refused
        send_request(OP_LOOKUP, 31'd5, '0, '0);
        send_request(OP_LOOKUP, '0, '0, '0);                 // stored zero still not found
        send_request(OP_REMOVE_KEY, '0, '0, '0);
        send_request(OP_LOOKUP, 31'd7, '0, '0);              // miss, insertion point
        send_request(OP_LOOKUP, '1, '0, '0);
        send_request(OP_READ_POS, '0, '0, 6'd0);
        send_request(OP_READ_POS, '0, '0, 6'd1);
        send_request(OP_READ_POS, '0, '0, 6'd2);
        send_request(OP_READ_POS, '0, '0, 6'd3);             // at count, bad
        send_request(OP_REMOVE_KEY, 31'd5, '0, '0);
        send_request(OP_REMOVE_KEY, 31'd5, '0, '0);          // already gone
        send_request(3'd5, '1, '1, '1);                      // reserved opcodes
        send_request(3'd6, 31'd5, '0, '0);
        send_request(3'd7, '0, '1, 6'd1);
        send_request(OP_REMOVE_POS, '0, '0, 6'd0);
        send_request(OP_REMOVE_POS, '0, '0, 6'd0);
        send_request(OP_REMOVE_POS, '0, '0, 6'd0);           // table now empty
        wait_idle();

        // phases over the register settings; table contents carry over,
        // so an order flip also searches a table sorted the other way
        write_register(REG_DESCENDING, 1'b0);
        write_register(REG_UNIQUE_KEYS, 1'b1);
        random_phase(1'b1);
        wait_idle();

        write_register(REG_DESCENDING, 1'b1);
        random_phase(1'b0);
        wait_idle();

        write_register(REG_UNIQUE_KEYS, 1'b0);
        random_phase(1'b0);
        wait_idle();

        write_register(REG_DESCENDING, 1'b0);
        random_phase(1'b1);
        wait_idle();

        // let any trailing activity settle
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("sorted_key_table_tb OK");
        else
            $display("sorted_key_table_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/skt_pkg.sv
rtl/skt_ram.sv
rtl/skt_engine.sv
rtl/sorted_key_table.sv
rtl/skt_checker.sv
verif/sorted_key_table_checker.sv
verif/sorted_key_table_tb.sv
